// ----- src/ssd_pkg.sv -----
`default_nettype none
package ssd_pkg;

	localparam int ACTION_W   = 2;
	localparam int CHAR_W     = 8;
	localparam int SEG_W      = 8;
	localparam int SEL_W      = 3;
	localparam int INTERVAL_W = 9;

	localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_CHAR  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] ASCII_DOT   = 8'h2E;

	localparam logic [SEG_W-1:0] SEG_G   = 8'h40;
	localparam logic [SEG_W-1:0] SEG_DOT = 8'h80;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 9'd500;

	typedef struct packed {
		logic             is_glyph;
		logic             is_dot;
		logic [SEG_W-1:0] pattern;
	} char_class_t;

	function automatic logic [SEG_W-1:0] digit_pattern(input logic [3:0] d);
		logic [SEG_W-1:0] p;
		case (d)
			4'd0:    p = 8'h3F;
			4'd1:    p = 8'h06;
			4'd2:    p = 8'h5B;
			4'd3:    p = 8'h4F;
			4'd4:    p = 8'h66;
			4'd5:    p = 8'h6D;
			4'd6:    p = 8'h7D;
			4'd7:    p = 8'h07;
			4'd8:    p = 8'h7F;
			4'd9:    p = 8'h6F;
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

// ----- src/ssd_if.sv -----
`default_nettype none
interface ssd_in_if import ssd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [CHAR_W-1:0]   char_code;
	logic                new_string;

	modport source (output valid, action, char_code, new_string, input ready);
	modport sink   (input valid, action, char_code, new_string, output ready);
endinterface

interface ssd_out_if import ssd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SEG_W-1:0] segments;
	logic [SEL_W-1:0] digit_select;
	logic             measure_pulse;
	logic             char_stored;

	modport source (output valid, segments, digit_select, measure_pulse, char_stored,
		input ready);
	modport sink   (input valid, segments, digit_select, measure_pulse, char_stored,
		output ready);
endinterface
`default_nettype wire

// ----- src/ssd_char_dec.sv -----
`default_nettype none
module ssd_char_dec import ssd_pkg::*; (
	input  wire logic [CHAR_W-1:0] char_code,
	output char_class_t            cls
);

	logic is_digit;
	logic is_minus;

	assign is_digit = (char_code >= ASCII_ZERO) && (char_code <= ASCII_NINE);
	assign is_minus = (char_code == ASCII_MINUS);

	always_comb begin
		cls.is_glyph = is_digit || is_minus;
		cls.is_dot   = (char_code == ASCII_DOT);
		if (is_digit) begin
			cls.pattern = digit_pattern(char_code[3:0]);
		end else if (is_minus) begin
			cls.pattern = SEG_G;
		end else begin
			cls.pattern = '0;
		end
	end

endmodule
`default_nettype wire

// ----- src/seven_segment_display_driver.sv -----
`default_nettype none
// Multiplexed seven-segment driver. Each word on item carries an action: a scan
// tick drives the next digit's pattern and one-hot cathode (digit i on bit i,
// digits past the third read 0) and pulses measure_pulse every
// cfg_wdata+1 ticks; a character stores a digit, minus or dot into the digit
// store (new_string restarts at digit 0, characters past the last digit are
// dropped); a clear zeroes the store. Every word yields exactly one result
// word, registered in the cycle after acceptance; one word can be accepted
// every cycle, limited only by result backpressure through the single
// output register. Segment bits 0..7 are a..g and dot.
module seven_segment_display_driver import ssd_pkg::*; #(
	parameter int DIGITS = 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [INTERVAL_W-1:0] cfg_wdata,
	ssd_in_if.sink                     item,
	ssd_out_if.source                  result
);

	localparam int SW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int WW = $clog2(DIGITS + 1);

	logic [INTERVAL_W-1:0] interval_q;
	logic [SEG_W-1:0]      store_q [DIGITS];
	logic [SW-1:0]         scan_q;
	logic [WW-1:0]         wpos_q;
	logic [INTERVAL_W-1:0] div_q;
	logic [SEG_W-1:0]      seg_drive_q;
	logic [SEL_W-1:0]      sel_drive_q;

	logic                  res_valid_q;
	logic [SEG_W-1:0]      res_seg_q;
	logic [SEL_W-1:0]      res_sel_q;
	logic                  res_pulse_q;
	logic                  res_stored_q;

	char_class_t           cls;
	logic                  accept;
	logic                  is_tick;
	logic                  is_char;
	logic                  is_clear;
	logic [WW-1:0]         wpos_eff;
	logic                  has_room;
	logic                  put_glyph;
	logic                  put_dot;
	logic                  stored;
	logic [SEG_W-1:0]      seg_next;
	logic [SEL_W-1:0]      sel_next;
	logic [SEL_W-1:0]      sel_tick;
	logic [INTERVAL_W:0]   div_inc;
	logic                  pulse;

	ssd_char_dec u_dec (
		.char_code(item.char_code),
		.cls      (cls)
	);

	assign item.ready = !res_valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	assign is_tick  = (item.action == ACT_TICK);
	assign is_char  = (item.action == ACT_CHAR);
	assign is_clear = (item.action == ACT_CLEAR);

	assign wpos_eff  = item.new_string ? '0 : wpos_q;
	assign has_room  = (wpos_eff < WW'(DIGITS));
	assign put_glyph = is_char && has_room && cls.is_glyph;
	assign put_dot   = is_char && has_room && cls.is_dot && (wpos_eff != '0);
	assign stored    = put_glyph || put_dot;

	always_comb begin
		for (int i = 0; i < SEL_W; i++) begin
			sel_tick[i] = (i < DIGITS) && (int'(scan_q) == i);
		end
	end

	assign seg_next = is_tick ? store_q[scan_q] : seg_drive_q;
	assign sel_next = is_tick ? sel_tick : sel_drive_q;
	assign div_inc  = {1'b0, div_q} + 1'b1;
	assign pulse    = is_tick && (div_inc > {1'b0, interval_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (cfg_we) begin
			interval_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) begin
				store_q[i] <= '0;
			end
			scan_q      <= '0;
			wpos_q      <= '0;
			div_q       <= '0;
			seg_drive_q <= '0;
			sel_drive_q <= '0;
		end else if (accept) begin
			seg_drive_q <= seg_next;
			sel_drive_q <= sel_next;
			if (is_tick) begin
				scan_q <= (scan_q == SW'(DIGITS - 1)) ? '0 : scan_q + 1'b1;
				div_q  <= pulse ? '0 : div_inc[INTERVAL_W-1:0];
			end
			if (is_char) begin
				wpos_q <= put_glyph ? wpos_eff + 1'b1 : wpos_eff;
			end
			// dot lands on the digit written last, glyph on the current slot
			for (int i = 0; i < DIGITS; i++) begin
				if (is_clear) begin
					store_q[i] <= '0;
				end else if (put_glyph && (WW'(i) == wpos_eff)) begin
					store_q[i] <= cls.pattern;
				end else if (put_dot && (WW'(i + 1) == wpos_eff)) begin
					store_q[i] <= store_q[i] | SEG_DOT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (item.ready) begin
			res_valid_q <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_seg_q    <= seg_next;
			res_sel_q    <= sel_next;
			res_pulse_q  <= pulse;
			res_stored_q <= stored;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.segments      = res_seg_q;
	assign result.digit_select  = res_sel_q;
	assign result.measure_pulse = res_pulse_q;
	assign result.char_stored   = res_stored_q;

endmodule
`default_nettype wire
